>>> sv/nt2_pkg.sv
`timescale 1ns / 1ps

package nt2_pkg;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] frame_byte0;
		logic [7:0] frame_byte1;
		logic [7:0] frame_byte2;
		logic [7:0] frame_byte3;
		logic [7:0] frame_byte4;
		logic [7:0] frame_byte5;
	} request_t;

	typedef struct packed {
		logic [1:0] reply_kind;
		logic [7:0] reply_byte;
		logic       last_of_reply;
	} reply_t;

	// controller to datapath
	typedef struct packed {
		logic init_start;
		logic init_step;
		logic ld_read;
		logic ld_fast;
		logic ld_ver;
		logic wr_page;
		logic wr_compat;
		logic tgt_frame;
		logic tgt_sector;
		logic tgt_clear;
		logic emit_nib;
		logic ack;
		logic emit_halt;
		logic emit_page;
		logic emit_ver;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic b1_ok;
		logic wr_ok;
		logic fast_ok;
		logic init_last;
		logic page_last;
		logic ver_last;
	} sts_t;

	localparam int CFG_W = 48;

	localparam logic CFG_MFR    = 1'b0;
	localparam logic CFG_SERIAL = 1'b1;

	localparam logic [1:0] ACT_FRAME   = 2'd0;
	localparam logic [1:0] ACT_SESSION = 2'd1;
	localparam logic [1:0] ACT_INIT    = 2'd2;

	localparam logic [1:0] KIND_DATA   = 2'd0;
	localparam logic [1:0] KIND_NIBBLE = 2'd1;
	localparam logic [1:0] KIND_HALT   = 2'd2;

	localparam logic [7:0] OP_READ          = 8'h30;
	localparam logic [7:0] OP_FAST_READ     = 8'h3a;
	localparam logic [7:0] OP_GET_VERSION   = 8'h60;
	localparam logic [7:0] OP_COMPAT_WRITE  = 8'ha0;
	localparam logic [7:0] OP_WRITE         = 8'ha2;
	localparam logic [7:0] OP_SECTOR_SELECT = 8'hc2;
	localparam logic [7:0] OP_HALT          = 8'h50;

	localparam logic [7:0] NIB_ACK = 8'h0a;
	localparam logic [7:0] NIB_NAK = 8'h00;

	localparam logic [7:0] BCC_SEED  = 8'h88;
	localparam logic [7:0] STAT_SAK  = 8'h48;
	localparam logic [7:0] CC_MAGIC  = 8'he1;
	localparam logic [7:0] CC_VER    = 8'h10;
	localparam logic [7:0] CC_ACCESS = 8'h0f;

	localparam logic [7:0] MIN_WR_PAGE = 8'd3;

	function automatic logic [7:0] version_byte(input logic [2:0] idx);
		logic [7:0] v;
		case (idx)
			3'd2:    v = 8'h03;
			3'd3:    v = 8'h01;
			3'd4:    v = 8'h01;
			3'd6:    v = 8'h0b;
			3'd7:    v = 8'h03;
			default: v = 8'h00;
		endcase
		return v;
	endfunction

endpackage

>>> sv/nt2_ctrl.sv
`timescale 1ns / 1ps

module nt2_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [1:0]        action,
	input  logic [7:0]        opcode,
	input  nt2_pkg::sts_t     sts,
	output nt2_pkg::cmd_t     cmd,
	output logic              busy
);
	import nt2_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_INIT   = 6'b000010,
		S_FETCH  = 6'b000100,
		S_PAGE   = 6'b001000,
		S_VFETCH = 6'b010000,
		S_VER    = 6'b100000
	} state_t;

	typedef enum logic [1:0] {
		PH_NONE   = 2'd0,
		PH_COMPAT = 2'd1,
		PH_SECTOR = 2'd2
	} phase_t;

	state_t state_q, state_d;
	phase_t pending_q, pending_d;
	logic   halted_q, halted_d;
	logic   accept;

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);

	always_comb begin
		cmd       = '0;
		state_d   = state_q;
		pending_d = pending_q;
		halted_d  = halted_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (action)
						ACT_INIT: begin
							cmd.init_start = 1'b1;
							state_d        = S_INIT;
						end
						ACT_SESSION: begin
							pending_d     = PH_NONE;
							halted_d      = 1'b0;
							cmd.tgt_clear = 1'b1;
						end
						ACT_FRAME: begin
							if (!halted_q) begin
								if (pending_q == PH_SECTOR) begin
									cmd.tgt_sector = 1'b1;
									pending_d      = PH_NONE;
									cmd.emit_nib   = 1'b1;
									cmd.ack        = 1'b1;
								end else if (pending_q == PH_COMPAT) begin
									cmd.wr_compat = 1'b1;
									pending_d     = PH_NONE;
									cmd.emit_nib  = 1'b1;
									cmd.ack       = 1'b1;
								end else begin
									pending_d = PH_NONE;
									unique case (opcode)
										OP_READ: begin
											if (sts.b1_ok) begin
												cmd.ld_read = 1'b1;
												state_d     = S_FETCH;
											end else begin
												cmd.emit_nib = 1'b1;
											end
										end
										OP_FAST_READ: begin
											if (sts.fast_ok) begin
												cmd.ld_fast = 1'b1;
												state_d     = S_FETCH;
											end else begin
												cmd.emit_nib = 1'b1;
											end
										end
										OP_GET_VERSION: begin
											cmd.ld_ver = 1'b1;
											state_d    = S_VFETCH;
										end
										OP_COMPAT_WRITE: begin
											cmd.emit_nib = 1'b1;
											if (sts.wr_ok) begin
												cmd.tgt_frame = 1'b1;
												cmd.ack       = 1'b1;
												pending_d     = PH_COMPAT;
											end
										end
										OP_WRITE: begin
											cmd.emit_nib = 1'b1;
											cmd.ack      = sts.wr_ok;
											cmd.wr_page  = sts.wr_ok;
										end
										OP_SECTOR_SELECT: begin
											cmd.emit_nib = 1'b1;
											cmd.ack      = 1'b1;
											pending_d    = PH_SECTOR;
										end
										OP_HALT: begin
											cmd.emit_halt = 1'b1;
											halted_d      = 1'b1;
										end
										default: begin
											cmd.emit_nib = 1'b1;
										end
									endcase
								end
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_INIT: begin
				cmd.init_step = 1'b1;
				if (sts.init_last) begin
					state_d = S_IDLE;
				end
			end
			S_FETCH: begin
				state_d = S_PAGE;
			end
			S_PAGE: begin
				cmd.emit_page = 1'b1;
				if (sts.page_last) begin
					state_d = S_IDLE;
				end
			end
			S_VFETCH: begin
				state_d = S_VER;
			end
			S_VER: begin
				cmd.emit_ver = 1'b1;
				if (sts.ver_last) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			pending_q <= PH_NONE;
			halted_q  <= 1'b0;
		end else begin
			state_q   <= state_d;
			pending_q <= pending_d;
			halted_q  <= halted_d;
		end
	end

	// a halted tag stays silent on frames
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && action == ACT_FRAME && halted_q) |-> !(cmd.emit_nib || cmd.emit_halt ||
			cmd.wr_page || cmd.wr_compat || cmd.ld_read || cmd.ld_fast || cmd.ld_ver))
		else $error("frame acted on while halted");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INIT && sts.init_last) |=> state_q == S_IDLE)
		else $error("init sweep overran");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_halt |=> halted_q)
		else $error("halt reply without halted flag");

endmodule

>>> sv/nt2_dpath.sv
`timescale 1ns / 1ps

module nt2_dpath #(
	parameter int PAGES = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic                     cfg_index,
	input  logic [nt2_pkg::CFG_W-1:0] cfg_data,
	input  nt2_pkg::request_t        request,
	input  nt2_pkg::cmd_t            cmd,
	output nt2_pkg::sts_t            sts,
	output nt2_pkg::reply_t          result,
	output logic                     result_stb
);
	import nt2_pkg::*;

	localparam int PW = (PAGES > 1) ? $clog2(PAGES) : 1;
	localparam logic [7:0] PAGES_B  = 8'(PAGES);
	localparam logic [7:0] CC_SIZE  = 8'(PAGES / 2 - 1);
	localparam logic [PW-1:0] LAST_PG = PW'(PAGES - 1);

	logic [7:0]        mfr_q;
	logic [CFG_W-1:0]  serial_q;
	logic [7:0]        tgt_q;
	logic [2:0]        ctr_q;
	logic [PW-1:0]     page_q;
	logic [PW-1:0]     rem_q;
	logic [PAGES-1:0]  valid_q;
	logic [31:0]       mem_q [PAGES];
	logic [31:0]       rdata_q;
	logic              rvld_q;
	reply_t            out_q;
	logic              out_stb_q;

	logic              advance;
	logic [PW-1:0]     page_nxt;
	logic [PW-1:0]     raddr;
	logic              wr_en;
	logic [PW-1:0]     wr_row;
	logic [31:0]       wr_data;
	logic [31:0]       init_word;
	logic [7:0]        bcc0;
	logic [7:0]        bcc1;
	logic [7:0]        fast_diff;
	logic [7:0]        page_byte;
	logic [7:0]        ver_byte;
	logic              tgt_ok;
	logic              any_emit;

	// status for the controller
	always_comb begin
		sts.b1_ok     = request.frame_byte1 < PAGES_B;
		sts.wr_ok     = sts.b1_ok && (request.frame_byte1 >= MIN_WR_PAGE);
		sts.fast_ok   = sts.b1_ok && (request.frame_byte2 < PAGES_B) &&
			(request.frame_byte1 <= request.frame_byte2);
		sts.init_last = (ctr_q[1:0] == 2'd3);
		sts.page_last = (ctr_q[1:0] == 2'd3) && (rem_q == '0);
		sts.ver_last  = (ctr_q == 3'd7);
	end

	assign fast_diff = request.frame_byte2 - request.frame_byte1;
	assign advance   = cmd.emit_page && (ctr_q[1:0] == 2'd3);
	assign page_nxt  = (page_q == LAST_PG) ? '0 : page_q + 1'b1;
	assign raddr     = advance ? page_nxt : page_q;
	assign tgt_ok    = tgt_q < PAGES_B;

	// rows 0..3 of a freshly initialized tag, byte k in bits 8k+7..8k
	assign bcc0 = mfr_q ^ serial_q[47:40] ^ serial_q[39:32] ^ BCC_SEED;
	assign bcc1 = serial_q[31:24] ^ serial_q[23:16] ^ serial_q[15:8] ^ serial_q[7:0];

	always_comb begin
		case (ctr_q[1:0])
			2'd0:    init_word = {bcc0, serial_q[39:32], serial_q[47:40], mfr_q};
			2'd1:    init_word = {serial_q[7:0], serial_q[15:8], serial_q[23:16],
				serial_q[31:24]};
			2'd2:    init_word = {8'h00, 8'h00, STAT_SAK, bcc1};
			default: init_word = {CC_ACCESS, CC_SIZE, CC_VER, CC_MAGIC};
		endcase
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_row  = '0;
		wr_data = '0;
		if (cmd.init_step) begin
			wr_en   = 1'b1;
			wr_row  = PW'(ctr_q[1:0]);
			wr_data = init_word;
		end else if (cmd.wr_page) begin
			wr_en   = 1'b1;
			wr_row  = request.frame_byte1[PW-1:0];
			wr_data = {request.frame_byte5, request.frame_byte4,
				request.frame_byte3, request.frame_byte2};
		end else if (cmd.wr_compat && tgt_ok) begin
			wr_en   = 1'b1;
			wr_row  = tgt_q[PW-1:0];
			wr_data = {request.frame_byte3, request.frame_byte2,
				request.frame_byte1, request.frame_byte0};
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_row] <= wr_data;
		end
		rdata_q <= mem_q[raddr];
		rvld_q  <= valid_q[raddr];
	end

	// a page never written since reset or init reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.init_start) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_row] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mfr_q    <= 8'd4;
			serial_q <= '0;
			tgt_q    <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_MFR:    mfr_q    <= cfg_data[7:0];
					CFG_SERIAL: serial_q <= cfg_data;
					default:    ;
				endcase
			end
			if (cmd.tgt_clear) begin
				tgt_q <= '0;
			end else if (cmd.tgt_sector) begin
				tgt_q <= request.frame_byte0;
			end else if (cmd.tgt_frame) begin
				tgt_q <= request.frame_byte1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctr_q  <= '0;
			page_q <= '0;
			rem_q  <= '0;
		end else begin
			if (cmd.init_start || cmd.ld_read || cmd.ld_fast || cmd.ld_ver) begin
				ctr_q <= '0;
			end else if (cmd.init_step || cmd.emit_page || cmd.emit_ver) begin
				ctr_q <= ctr_q + 1'b1;
			end
			if (cmd.ld_read) begin
				page_q <= request.frame_byte1[PW-1:0];
				rem_q  <= PW'(3);
			end else if (cmd.ld_fast) begin
				page_q <= request.frame_byte1[PW-1:0];
				rem_q  <= fast_diff[PW-1:0];
			end else if (cmd.ld_ver) begin
				page_q <= '0;
			end else if (advance) begin
				page_q <= page_nxt;
				rem_q  <= rem_q - 1'b1;
			end
		end
	end

	assign page_byte = rvld_q ? rdata_q[8 * ctr_q[1:0] +: 8] : 8'h00;
	assign ver_byte  = (ctr_q == 3'd1) ? (rvld_q ? rdata_q[7:0] : 8'h00)
		: version_byte(ctr_q);
	assign any_emit  = cmd.emit_nib || cmd.emit_halt || cmd.emit_page || cmd.emit_ver;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stb_q <= 1'b0;
		end else begin
			out_stb_q <= any_emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_nib) begin
			out_q <= '{reply_kind: KIND_NIBBLE, reply_byte: (cmd.ack ? NIB_ACK : NIB_NAK),
				last_of_reply: 1'b1};
		end else if (cmd.emit_halt) begin
			out_q <= '{reply_kind: KIND_HALT, reply_byte: 8'h00, last_of_reply: 1'b1};
		end else if (cmd.emit_page) begin
			out_q <= '{reply_kind: KIND_DATA, reply_byte: page_byte,
				last_of_reply: sts.page_last};
		end else if (cmd.emit_ver) begin
			out_q <= '{reply_kind: KIND_DATA, reply_byte: ver_byte,
				last_of_reply: sts.ver_last};
		end
	end

	assign result     = out_q;
	assign result_stb = out_stb_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.emit_nib, cmd.emit_halt, cmd.emit_page, cmd.emit_ver}))
		else $error("conflicting emit commands");

	assert property (@(posedge clk) disable iff (!arst_n)
		any_emit |=> out_stb_q)
		else $error("emitted word not strobed");

	assert property (@(posedge clk) disable iff (!arst_n)
		!any_emit |=> !out_stb_q)
		else $error("strobe without emitted word");

endmodule

>>> sv/nfc_type2_tag_responder.sv
`timescale 1ns / 1ps
// Nibble and halt replies: one word, strobed in the cycle after start; busy stays low.
// READ, FAST_READ, GET_VERSION: busy through one page fetch, then one word per cycle
// (16 words, 4 per page, or 8); first word strobed after the FETCH and PAGE states and the output register.
// Initialize: busy while page rows 0..3 are written, one page row of the tag memory per cycle.
// Reset clears control state and the page valid bits, so the whole memory reads zero.
// Results cannot be held off: each word is strobed for exactly one cycle.
module nfc_type2_tag_responder #(
	parameter int PAGES = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  nt2_pkg::request_t         request,
	output nt2_pkg::reply_t           result,
	output logic                      result_stb,
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [nt2_pkg::CFG_W-1:0] cfg_data
);
	import nt2_pkg::*;

	cmd_t cmd;
	sts_t sts;

	nt2_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.action (request.action),
		.opcode (request.frame_byte0),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	nt2_dpath #(
		.PAGES (PAGES)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.request    (request),
		.cmd        (cmd),
		.sts        (sts),
		.result     (result),
		.result_stb (result_stb)
	);

endmodule
